>>> rtl/periodic_displacement_histogram_macros.svh
// Assertion macros shared by the histogram block.
`ifndef PERIODIC_DISPLACEMENT_HISTOGRAM_MACROS_SVH
`define PERIODIC_DISPLACEMENT_HISTOGRAM_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define PDH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdh assertion failed");
// Next-cycle implication, checked out of reset.
`define PDH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdh assertion failed");
`else
`define PDH_ASSERT_IMP(lbl, ante, cons)
`define PDH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/pdh_pkg.sv
package pdh_pkg;

  localparam int unsigned NUM_BINS    = 256;
  localparam int unsigned NUM_SPECIES = 3;
  localparam int unsigned BIN_W       = $clog2(NUM_BINS);
  localparam int unsigned NUM_ENTRIES = NUM_BINS * NUM_SPECIES;
  localparam int unsigned ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int unsigned STEP_W      = 5;

  // Command codes of a request.
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_AXIS_MODE  = 3'd0,
    REG_BOX_SIZE   = 3'd1,
    REG_BIN_WIDTH  = 3'd2,
    REG_BINS_USED  = 3'd3,
    REG_FAR_THRESH = 3'd4,
    REG_LIMIT_LOW  = 3'd5,
    REG_LIMIT_HIGH = 3'd6
  } pdh_reg_e;

  typedef struct packed {
    logic        command;
    logic [30:0] old_x;
    logic [30:0] old_y;
    logic [30:0] old_z;
    logic [30:0] new_x;
    logic [30:0] new_y;
    logic [30:0] new_z;
    logic [15:0] charge;
    logic [1:0]  read_species;
    logic [7:0]  read_bin;
  } pdh_in_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [1:0]  species;
    logic [7:0]  bin_index;
    logic        bin_hit;
    logic [31:0] bin_count;
    logic [63:0] square_sum;
  } pdh_out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MIN, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_ROOT_INIT,
    S_ROOT, S_RSQ, S_DIV, S_SUM, S_MRD, S_MWR, S_OUT
  } pdh_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clr;
    logic       load;
    logic       mimg;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_ld;
    logic       acc_add;
    logic       root_init;
    logic       root_step;
    logic       rsq;
    logic       div_step;
    logic       sum_upd;
    logic       mem_rd;
    logic       mem_wr;
    logic       out_ld;
  } pdh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic step_last;
    logic is_read;
    logic mode3d;
    logic out_free;
  } pdh_stat_t;

endpackage

>>> rtl/pdh_ctrl.sv
module pdh_ctrl import pdh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  pdh_stat_t  stat_i,
  output pdh_cmd_t   cmd_o
);

  pdh_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:     if (stat_i.clr_last) state_d = S_IDLE;
      S_IDLE:      if (in_valid_i) state_d = S_MIN;
      S_MIN:       begin
        if (stat_i.is_read) state_d = S_MRD;
        else if (stat_i.mode3d) state_d = S_SQ0;
        else state_d = S_RSQ;
      end
      S_SQ0:       state_d = S_SQ1;
      S_SQ1:       state_d = S_SQ2;
      S_SQ2:       state_d = S_SQ3;
      S_SQ3:       state_d = S_ROOT_INIT;
      S_ROOT_INIT: state_d = S_ROOT;
      S_ROOT:      if (stat_i.step_last) state_d = S_RSQ;
      S_RSQ:       state_d = S_DIV;
      S_DIV:       if (stat_i.step_last) state_d = S_SUM;
      S_SUM:       state_d = S_MRD;
      S_MRD:       state_d = S_MWR;
      S_MWR:       state_d = S_OUT;
      S_OUT:       if (stat_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR:     cmd_o.clr = 1'b1;
      S_IDLE:      begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_MIN:       cmd_o.mimg = 1'b1;
      S_SQ0:       begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = 2'd0;
      end
      S_SQ1:       begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = 2'd1;
        cmd_o.acc_ld  = 1'b1;
      end
      S_SQ2:       begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = 2'd2;
        cmd_o.acc_add = 1'b1;
      end
      S_SQ3:       cmd_o.acc_add   = 1'b1;
      S_ROOT_INIT: cmd_o.root_init = 1'b1;
      S_ROOT:      cmd_o.root_step = 1'b1;
      S_RSQ:       cmd_o.rsq       = 1'b1;
      S_DIV:       cmd_o.div_step  = 1'b1;
      S_SUM:       cmd_o.sum_upd   = 1'b1;
      S_MRD:       cmd_o.mem_rd    = 1'b1;
      S_MWR:       cmd_o.mem_wr    = 1'b1;
      S_OUT:       cmd_o.out_ld    = stat_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

endmodule

>>> rtl/pdh_dp.sv
module pdh_dp import pdh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  pdh_in_t     in_i,
  input  pdh_cmd_t    cmd_i,
  output pdh_stat_t   stat_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pdh_out_t    out_o
);

  // Minimum periodic image of one axis difference.
  function automatic logic [30:0] min_image(logic [30:0] oldp, logic [30:0] newp,
                                            logic [30:0] box);
    logic signed [33:0] d, a0, a1, a2;
    d  = $signed({3'b000, newp}) - $signed({3'b000, oldp});
    a1 = d - $signed({3'b000, box});
    a2 = d + $signed({3'b000, box});
    a0 = d[33] ? -d : d;
    if (a1[33]) a1 = -a1;
    if (a2[33]) a2 = -a2;
    if (a1 < a0) a0 = a1;
    if (a2 < a0) a0 = a2;
    return a0[30:0];
  endfunction

  // Configuration registers.
  logic [1:0]  axis_mode_q;
  logic [30:0] box_size_q, bin_width_q;
  logic [8:0]  bins_used_q;
  logic [31:0] far_thresh_q;
  logic [15:0] limit_low_q, limit_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_mode_q  <= 2'd0;
      box_size_q   <= 31'd6553600;
      bin_width_q  <= 31'd25600;
      bins_used_q  <= 9'd256;
      far_thresh_q <= 32'd1048576;
      limit_low_q  <= 16'd1792;
      limit_high_q <= 16'd2304;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_AXIS_MODE:  axis_mode_q  <= cfg_wdata_i[1:0];
        REG_BOX_SIZE:   box_size_q   <= cfg_wdata_i[30:0];
        REG_BIN_WIDTH:  bin_width_q  <= cfg_wdata_i[30:0];
        REG_BINS_USED:  bins_used_q  <= cfg_wdata_i[8:0];
        REG_FAR_THRESH: far_thresh_q <= cfg_wdata_i;
        REG_LIMIT_LOW:  limit_low_q  <= cfg_wdata_i[15:0];
        REG_LIMIT_HIGH: limit_high_q <= cfg_wdata_i[15:0];
        default:        ;
      endcase
    end
  end

  // Request capture, axis images, species and distance.
  pdh_in_t     req_q;
  logic [30:0] x_q, y_q, z_q, mul_op;
  logic [1:0]  sp_q;
  logic [31:0] r_q;
  logic [61:0] prod_q;
  logic [63:0] acc_q, sqr_q;

  // Iterative square root and divider share one step counter.
  logic [STEP_W-1:0] step_q;
  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q, quo_q, drem_q;
  logic [35:0] rem_sh, root_t;
  logic [31:0] root_nx;
  logic [33:0] rem_nx;
  logic [31:0] dsh;

  always_comb begin
    unique case (cmd_i.mul_sel)
      2'd0:    mul_op = x_q;
      2'd1:    mul_op = y_q;
      default: mul_op = z_q;
    endcase
    rem_sh = {rem_q, rad_q[63:62]};
    root_t = {2'b00, root_q, 2'b01};
    if (rem_sh >= root_t) begin
      rem_nx  = 34'(rem_sh - root_t);
      root_nx = {root_q[30:0], 1'b1};
    end else begin
      rem_nx  = rem_sh[33:0];
      root_nx = {root_q[30:0], 1'b0};
    end
    dsh = {drem_q[30:0], quo_q[31]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_i;
    if (cmd_i.mimg) begin
      x_q <= min_image(req_q.old_x, req_q.new_x, box_size_q);
      y_q <= min_image(req_q.old_y, req_q.new_y, box_size_q);
      z_q <= min_image(req_q.old_z, req_q.new_z, box_size_q);
      unique case (axis_mode_q)
        2'd1:    r_q <= {1'b0, min_image(req_q.old_x, req_q.new_x, box_size_q)};
        2'd2:    r_q <= {1'b0, min_image(req_q.old_y, req_q.new_y, box_size_q)};
        default: r_q <= {1'b0, min_image(req_q.old_z, req_q.new_z, box_size_q)};
      endcase
      if (req_q.charge < limit_low_q) sp_q <= 2'd0;
      else if (req_q.charge < limit_high_q) sp_q <= 2'd1;
      else sp_q <= 2'd2;
    end
    if (cmd_i.mul_en) prod_q <= mul_op * mul_op;
    if (cmd_i.acc_ld) acc_q <= {2'b00, prod_q};
    else if (cmd_i.acc_add) acc_q <= acc_q + {2'b00, prod_q};
    // Square root: two radicand bits per step.
    if (cmd_i.root_init) begin
      rad_q  <= acc_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= rem_nx;
      root_q <= root_nx;
      if (stat_o.step_last) r_q <= root_nx;
    end
    // Square of r, and divider start.
    if (cmd_i.rsq) begin
      sqr_q  <= r_q * r_q;
      quo_q  <= r_q;
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dsh >= {1'b0, bin_width_q}) begin
        drem_q <= dsh - {1'b0, bin_width_q};
        quo_q  <= {quo_q[30:0], 1'b1};
      end else begin
        drem_q <= dsh;
        quo_q  <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.root_init || cmd_i.rsq) begin
      step_q <= '0;
    end else if (cmd_i.root_step || cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end
  end

  // Species square sums, saturating.
  logic [63:0] sums_q [NUM_SPECIES];
  logic [64:0] sum_nx;
  logic [63:0] sum_sel;

  assign sum_sel = sums_q[sp_q];
  assign sum_nx  = {1'b0, sum_sel} + {17'd0, sqr_q[63:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SPECIES; i++) sums_q[i] <= '0;
    end else if (cmd_i.sum_upd && (r_q > far_thresh_q)) begin
      sums_q[sp_q] <= sum_nx[64] ? '1 : sum_nx[63:0];
    end
  end

  // Bin count memory, cleared by a sweep after reset.
  logic [31:0]       mem_q [NUM_ENTRIES];
  logic [31:0]       mem_rd_q, count_q, cnt_inc;
  logic [ADDR_W-1:0] clr_q, addr_q, rd_addr;
  logic              hit_q, hit_d, rs_ok;
  logic [8:0]        used;

  assign used    = (bins_used_q > 9'(NUM_BINS)) ? 9'(NUM_BINS) : bins_used_q;
  assign hit_d   = (bin_width_q != '0) && (quo_q < {23'd0, used});
  assign rs_ok   = (req_q.read_species < 2'(NUM_SPECIES));
  assign rd_addr = req_q.command == CMD_READ
                   ? (rs_ok ? {req_q.read_species, req_q.read_bin} : '0)
                   : {sp_q, quo_q[BIN_W-1:0]};
  assign cnt_inc = (mem_rd_q == '1) ? mem_rd_q : mem_rd_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.mem_wr && (req_q.command == CMD_ACCUM) && hit_q) begin
      mem_q[addr_q] <= cnt_inc;
    end
    if (cmd_i.mem_rd) begin
      mem_rd_q <= mem_q[rd_addr];
      addr_q   <= rd_addr;
      hit_q    <= (req_q.command == CMD_ACCUM) && hit_d;
    end
    if (cmd_i.mem_wr) begin
      if (req_q.command == CMD_READ) count_q <= rs_ok ? mem_rd_q : '0;
      else count_q <= hit_q ? cnt_inc : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_o.bin_count <= count_q;
      if (req_q.command == CMD_READ) begin
        out_o.distance   <= '0;
        out_o.species    <= req_q.read_species;
        out_o.bin_index  <= req_q.read_bin;
        out_o.bin_hit    <= 1'b0;
        out_o.square_sum <= rs_ok ? sums_q[req_q.read_species] : '0;
      end else begin
        out_o.distance   <= r_q;
        out_o.species    <= sp_q;
        out_o.bin_index  <= hit_q ? quo_q[BIN_W-1:0] : '0;
        out_o.bin_hit    <= hit_q;
        out_o.square_sum <= sum_sel;
      end
    end
  end

  // Status.
  assign stat_o.clr_last  = (clr_q == ADDR_W'(NUM_ENTRIES - 1));
  assign stat_o.step_last = (step_q == '1);
  assign stat_o.is_read   = (req_q.command == CMD_READ);
  assign stat_o.mode3d    = (axis_mode_q == 2'd0);
  assign stat_o.out_free  = !out_valid_o || !out_stall_i;

endmodule

>>> rtl/periodic_displacement_histogram.sv
// Periodic displacement histogram. After reset the block clears its bin
// count memory, one entry a cycle, and takes no request in that time. It
// handles one request at a time. A 3-D accumulate runs the
// one-bit-per-cycle square root (32 steps) and then the bin divider (32
// steps); a single-axis accumulate runs only the divider and a read
// neither. A waiting result that is still stalled holds the block in its
// last step. A finished result waits in an output register while the next
// request is taken. Configuration is to be written by the user only while
// the block is idle; the block itself does not enforce it.
`include "periodic_displacement_histogram_macros.svh"
module periodic_displacement_histogram import pdh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pdh_in_t     in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pdh_out_t    out_o
);

  pdh_cmd_t  cmd;
  pdh_stat_t stat;

  // Controller.
  pdh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  pdh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // One request at a time.
  `PDH_ASSERT_NXT(a_one_req, in_valid_i && !in_stall_o, in_stall_o)
  // A counted bin never reports a zero count.
  `PDH_ASSERT_IMP(a_hit_count, out_valid_o && out_o.bin_hit, out_o.bin_count != '0)
  // A counted particle has a real species.
  `PDH_ASSERT_IMP(a_hit_species, out_valid_o && out_o.bin_hit, out_o.species != 2'd3)

endmodule
